/* src/slls_pkg.sv */
// ----------------------------------------------------------------------------
// slls_pkg: shared types and constants of the sparse linear layer scorer
// Item and result beats, opcodes, store sizes and the beat that runs down
// the label cell chain.
// ----------------------------------------------------------------------------
package slls_pkg;

    localparam int NUM_LABELS     = 7;
    localparam int NUM_FEATURES   = 2048;
    localparam int NUM_OUT_SCORES = 7;

    localparam int LABEL_W = 3;
    localparam int FEAT_W  = 11;
    localparam int VAL_W   = 16;
    localparam int NODE_W  = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = 48;
    localparam int BIAS_SH = 14;

    // Feature index is 11 bits wide, so no more weight columns can be addressed.
    localparam int W_DEPTH  = (NUM_FEATURES < (1 << FEAT_W)) ? NUM_FEATURES : (1 << FEAT_W);
    localparam int W_ADDR_W = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_BIAS    = 2'd1;
    localparam logic [1:0] OP_FEATURE = 2'd2;

    typedef logic signed [SUM_W-1:0] t_score;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [LABEL_W-1:0]        label_index;
        logic [FEAT_W-1:0]         feature_index;
        logic signed [VAL_W-1:0]   value;
        logic [NODE_W-1:0]         node_id;
        logic                      last_of_node;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] node_out;
        t_score            score_0;
        t_score            score_1;
        t_score            score_2;
        t_score            score_3;
        t_score            score_4;
        t_score            score_5;
        t_score            score_6;
    } t_out;

    // One beat of the cell chain: the item plus the score slots filled so far.
    typedef struct packed {
        logic                              vld;
        t_in                               item;
        logic [NUM_OUT_SCORES-1:0][SUM_W-1:0] scores;
    } t_beat;

endpackage

/* src/slls_cell.sv */
// ----------------------------------------------------------------------------
// slls_cell: one label of the scorer
// Holds the weight column store, bias and accumulator of one label. A beat
// passes the cell's weight read, multiply and accumulate stages and then
// moves on to the next cell, with this label's score slot filled on a row's last feature beat.
// ----------------------------------------------------------------------------
module slls_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [slls_pkg::LABEL_W-1:0] i_label,
    input  slls_pkg::t_beat             i_beat,
    output slls_pkg::t_beat             o_beat
);
    import slls_pkg::*;

    logic signed [VAL_W-1:0]  r_wmem [W_DEPTH];
    logic signed [VAL_W-1:0]  r_w;
    logic signed [VAL_W-1:0]  r_bias;
    logic signed [PROD_W-1:0] r_p;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  n_acc;
    t_beat                    r_b1;
    t_beat                    r_b2;
    t_beat                    r_b3;
    t_beat                    n_b3;

    logic                     in_mine;
    logic                     in_feat_ok;
    logic                     b1_feat_ok;
    logic [W_ADDR_W-1:0]      in_addr;
    logic                     b2_feature;
    logic                     b2_bias;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  score;

    assign in_mine    = i_beat.vld && (i_beat.item.label_index == i_label);
    assign in_feat_ok = int'(i_beat.item.feature_index) < W_DEPTH;
    assign in_addr    = i_beat.item.feature_index[W_ADDR_W-1:0];
    assign b1_feat_ok = int'(r_b1.item.feature_index) < W_DEPTH;

    // Weight store: write and read at the cell entry, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (in_mine && in_feat_ok && i_beat.item.opcode == OP_WEIGHT) begin
                r_wmem[in_addr] <= i_beat.item.value;
            end
            r_w <= r_wmem[in_addr];
        end
    end

    // Take a bias write at the accumulate stage so it lines up with the beats ahead of it.
    assign b2_bias = r_b2.vld && r_b2.item.opcode == OP_BIAS
                     && r_b2.item.label_index == i_label;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (b2_bias) begin
                r_bias <= r_b2.item.value;
            end
            // Drop the product of an out-of-range column or of a non-feature beat.
            if (r_b1.vld && r_b1.item.opcode == OP_FEATURE && b1_feat_ok) begin
                r_p <= r_w * r_b1.item.value;
            end else begin
                r_p <= '0;
            end
        end
    end

    assign b2_feature = r_b2.vld && r_b2.item.opcode == OP_FEATURE;
    assign sum   = r_acc + {{(SUM_W-PROD_W){r_p[PROD_W-1]}}, r_p};
    assign score = sum + {{(SUM_W-VAL_W-BIAS_SH){r_bias[VAL_W-1]}}, r_bias, {BIAS_SH{1'b0}}};

    always_comb begin
        n_acc = r_acc;
        n_b3  = r_b2;
        if (b2_feature) begin
            if (r_b2.item.last_of_node) begin
                n_acc = '0;
                for (int j = 0; j < NUM_OUT_SCORES; j++) begin
                    if (LABEL_W'(j) == i_label) begin
                        n_b3.scores[j] = score;
                    end
                end
            end else begin
                n_acc = sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1.vld <= 1'b0;
            r_b2.vld <= 1'b0;
            r_b3.vld <= 1'b0;
            r_acc    <= '0;
        end else if (i_en) begin
            r_b1.vld <= i_beat.vld;
            r_b2.vld <= r_b1.vld;
            r_b3.vld <= n_b3.vld;
            r_acc    <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1.item   <= i_beat.item;
            r_b1.scores <= i_beat.scores;
            r_b2.item   <= r_b1.item;
            r_b2.scores <= r_b1.scores;
            r_b3.item   <= n_b3.item;
            r_b3.scores <= n_b3.scores;
        end
    end

    assign o_beat = r_b3;

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && b2_feature && r_b2.item.last_of_node) |=> (r_acc == '0))
        else $error("accumulator not cleared after last beat of a row");

endmodule

/* src/slls_out_buf.sv */
// ----------------------------------------------------------------------------
// slls_out_buf: result output register with skid stage
// Parts the chain from the receiver. The chain halts only while the skid
// entry is occupied, so the halt signal comes straight from a register.
// ----------------------------------------------------------------------------
module slls_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  slls_pkg::t_out     i_res,
    output logic               o_full,
    output logic               o_out_valid,
    output slls_pkg::t_out     o_out_data,
    input  logic               i_out_stall
);
    import slls_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    logic take;

    assign take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !take) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed while skid entry occupied");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost while receiver stalls");

endmodule

/* src/sparse_linear_layer_scores.sv */
// ----------------------------------------------------------------------------
// sparse_linear_layer_scores: sparse feature row times label weight matrix
// Scores graph nodes against per-label weights and biases loaded by
// weight and bias write items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / i_in_data / o_in_stall carries weight writes,
//   bias writes and feature nonzeros. Output channel o_out_valid /
//   o_out_data / i_out_stall carries one beat per feature item marked last:
//   the node number and one biased score per label.
//   Items run down a chain of NUM_LABELS label cells, three register stages
//   per cell (weight read, multiply, accumulate), then the output register.
//   Throughput is one item per cycle, writes and nonzeros alike, while o_in_stall is low.
//   When the receiver stalls, the waiting result holds and one more result
//   goes to a skid entry; o_in_stall rises only while that entry is full,
//   and then the whole chain holds.
//   Reset clears the accumulators and all beat valid bits. Weights and
//   biases are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module sparse_linear_layer_scores (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  slls_pkg::t_in    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output slls_pkg::t_out   o_out_data,
    input  logic             i_out_stall
);
    import slls_pkg::*;

    t_beat w_chain [NUM_LABELS+1];
    t_beat last_beat;
    t_out  res;
    logic  full;
    logic  en;
    logic  push;

    assign en = !full;

    always_comb begin
        w_chain[0].vld    = i_in_valid && en;
        w_chain[0].item   = i_in_data;
        w_chain[0].scores = '0;
    end

    for (genvar g = 0; g < NUM_LABELS; g++) begin : g_cell
        slls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_label (LABEL_W'(g)),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    assign last_beat = w_chain[NUM_LABELS];
    assign push = en && last_beat.vld && last_beat.item.opcode == OP_FEATURE
                  && last_beat.item.last_of_node;

    always_comb begin
        res.node_out = last_beat.item.node_id;
        res.score_0  = last_beat.scores[0];
        res.score_1  = last_beat.scores[1];
        res.score_2  = last_beat.scores[2];
        res.score_3  = last_beat.scores[3];
        res.score_4  = last_beat.scores[4];
        res.score_5  = last_beat.scores[5];
        res.score_6  = last_beat.scores[6];
    end

    slls_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (res),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    assign o_in_stall = full;

endmodule

/* tb/tb_sparse_linear_layer_scores.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_linear_layer_scores: self-checking bench for the sparse scorer
// Loads weight and bias stores, streams feature rows and checks every result
// beat against a local score predictor. A directed table covers the extremes,
// ignored writes, the spare opcode and empty rows; random rows follow, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_sparse_linear_layer_scores;
    import slls_pkg::*;

    localparam int          CLK_HALF    = 4;
    localparam int          RESET_LEN   = 7;
    localparam int          ITEM_TARGET = 1300;
    localparam logic [1:0]  OP_SPARE    = 2'd3;

    typedef struct {
        t_in  item;
        bit   all_labels;
        bit   typed;
        t_out want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;
    logic out_stall = 1'b0;

    // local copy of the block state
    logic signed [VAL_W-1:0] weight_mem [NUM_LABELS][NUM_FEATURES];
    bit                      weight_set [NUM_LABELS][NUM_FEATURES];
    bit                      col_ready  [NUM_FEATURES];
    int unsigned             ready_cols [$];
    logic signed [VAL_W-1:0] bias_mem   [NUM_LABELS];
    logic signed [SUM_W-1:0] label_acc  [NUM_LABELS];

    t_out        pending_scores [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned recv_hold      = 0;
    bit          no_gaps        = 1'b0;

    sparse_linear_layer_scores dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic t_in make_item(input logic [1:0] op, input int lab, input int feat,
                                      input int val, input int node, input bit last);
        t_in it;
        it.opcode        = op;
        it.label_index   = LABEL_W'(lab);
        it.feature_index = FEAT_W'(feat);
        it.value         = VAL_W'(val);
        it.node_id       = NODE_W'(node);
        it.last_of_node  = last;
        return it;
    endfunction

    function automatic t_out uniform_result(input int node, input t_score s);
        t_out r;
        r = '{NODE_W'(node), s, s, s, s, s, s, s};
        return r;
    endfunction

    function automatic int draw_value();
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // Advance the local state by one item; flag and return the result it gives.
    task automatic score_item(input t_in it, output bit fires, output t_out res);
        logic signed [SUM_W-1:0] prod;
        logic signed [SUM_W-1:0] biased;
        t_score                  sc [NUM_OUT_SCORES];
        bit                      full;
        fires = 1'b0;
        res   = '0;
        case (it.opcode)
            OP_WEIGHT: begin
                if (it.label_index < NUM_LABELS && it.feature_index < NUM_FEATURES) begin
                    weight_mem[it.label_index][it.feature_index] = it.value;
                    weight_set[it.label_index][it.feature_index] = 1'b1;
                    if (!col_ready[it.feature_index]) begin
                        full = 1'b1;
                        for (int l = 0; l < NUM_LABELS; l++)
                            full &= weight_set[l][it.feature_index];
                        if (full) begin
                            col_ready[it.feature_index] = 1'b1;
                            ready_cols.push_back(it.feature_index);
                        end
                    end
                end
            end
            OP_BIAS: begin
                if (it.label_index < NUM_LABELS)
                    bias_mem[it.label_index] = it.value;
            end
            OP_FEATURE: begin
                if (it.feature_index < NUM_FEATURES) begin
                    for (int l = 0; l < NUM_LABELS; l++) begin
                        prod         = weight_mem[l][it.feature_index] * it.value;
                        label_acc[l] = label_acc[l] + prod;
                    end
                end
                if (it.last_of_node) begin
                    for (int j = 0; j < NUM_OUT_SCORES; j++) begin
                        sc[j] = '0;
                        if (j < NUM_LABELS) begin
                            biased = bias_mem[j];
                            sc[j]  = label_acc[j] + (biased <<< BIAS_SH);
                        end
                    end
                    res = '{it.node_id, sc[0], sc[1], sc[2], sc[3], sc[4], sc[5], sc[6]};
                    for (int l = 0; l < NUM_LABELS; l++)
                        label_acc[l] = '0;
                    fires = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Drive one beat after a random gap, wait for acceptance, then predict.
    task automatic send_item(input t_in it, input bit typed, input t_out want);
        int unsigned gap;
        bit          fires;
        t_out        res;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        score_item(it, fires, res);
        if (fires)
            pending_scores.push_back(typed ? want : res);
        items_sent++;
    endtask

    function automatic int pick_ready_col();
        return int'(ready_cols[$urandom_range(0, ready_cols.size() - 1)]);
    endfunction

    initial begin : stimulus
        dir_row_t    directed_rows [$];
        t_in         it;
        int unsigned pick;
        int          col;
        int          node;
        int          len;
        bit          abandon;

        for (int l = 0; l < NUM_LABELS; l++)
            label_acc[l] = '0;

        directed_rows.push_back('{make_item(OP_BIAS, 0, 0, -32768, 0, 0), 1'b1, 1'b0, '0});
        directed_rows.push_back('{make_item(OP_WEIGHT, 0, 0, 32767, 0, 0), 1'b1, 1'b0, '0});
        // empty row right after reset: bias only
        directed_rows.push_back('{make_item(OP_FEATURE, 0, 0, 0, 0, 1), 1'b0, 1'b1,
                                  uniform_result(0, -48'sd536870912)});
        directed_rows.push_back('{make_item(OP_FEATURE, 0, 0, 32767, 16'hFFFF, 1), 1'b0, 1'b1,
                                  uniform_result(16'hFFFF, 48'sd536805377)});
        directed_rows.push_back('{make_item(OP_WEIGHT, 0, 2047, -32768, 0, 0), 1'b1, 1'b0,
                                  '0});
        directed_rows.push_back('{make_item(OP_FEATURE, 3, 2047, -32768, 16'h0F0F, 0), 1'b0,
                                  1'b0, '0});
        directed_rows.push_back('{make_item(OP_FEATURE, 5, 0, 32767, 16'h5555, 1), 1'b0, 1'b0,
                                  '0});
        // out-of-range label writes and the spare opcode must leave no trace
        directed_rows.push_back('{make_item(OP_BIAS, 7, 0, 32767, 0, 1), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_item(OP_WEIGHT, 7, 2047, 1, 0, 1), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_item(OP_SPARE, 7, 0, 32767, 16'hFFFF, 1), 1'b0, 1'b0,
                                  '0});
        directed_rows.push_back('{make_item(OP_FEATURE, 7, 2047, 0, 16'h1234, 1), 1'b0, 1'b0,
                                  '0});

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            it = directed_rows[r].item;
            if (directed_rows[r].all_labels) begin
                for (int l = 0; l < NUM_LABELS; l++) begin
                    it.label_index = LABEL_W'(l);
                    send_item(it, 1'b0, '0);
                end
            end else begin
                send_item(it, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 2)
                no_gaps = !no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // fill a whole column so it can carry nonzeros
                col = $urandom_range(0, NUM_FEATURES - 1);
                for (int l = 0; l < NUM_LABELS; l++)
                    send_item(make_item(OP_WEIGHT, l, col, draw_value(), $urandom,
                                        1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (pick < 20) begin
                send_item(make_item(OP_WEIGHT, $urandom_range(0, 7),
                                    $urandom_range(0, NUM_FEATURES - 1), draw_value(),
                                    $urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (pick < 26) begin
                send_item(make_item(OP_BIAS, $urandom_range(0, 7), $urandom, draw_value(),
                                    $urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (pick < 30) begin
                send_item(make_item(OP_SPARE, $urandom, $urandom, $urandom, $urandom,
                                    1'($urandom_range(0, 1))), 1'b0, '0);
            end else begin
                node    = $urandom_range(0, 65535);
                pick    = $urandom_range(0, 99);
                len     = (pick < 10) ? 0 : (pick < 15) ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 8);
                abandon = ($urandom_range(0, 99) < 5);
                if (len == 0) begin
                    send_item(make_item(OP_FEATURE, $urandom_range(0, 7), pick_ready_col(),
                                        0, node, 1'b1), 1'b0, '0);
                end else begin
                    for (int k = 0; k < len; k++) begin
                        // slip a write into the middle of a row now and then
                        if ($urandom_range(0, 99) < 8)
                            send_item(make_item($urandom_range(0, 1) ? OP_WEIGHT : OP_BIAS,
                                                $urandom_range(0, 7), pick_ready_col(),
                                                draw_value(), $urandom, 1'b0), 1'b0, '0);
                        send_item(make_item(OP_FEATURE, $urandom_range(0, 7),
                                            pick_ready_col(), draw_value(), node,
                                            (k == len - 1) && !abandon), 1'b0, '0);
                    end
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_scores.size() != 0) @(posedge clk);
        repeat (3 * NUM_LABELS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge clk) begin : result_check
        t_out   want;
        t_score got_sc  [NUM_OUT_SCORES];
        t_score want_sc [NUM_OUT_SCORES];
        if (rst_n && out_valid && !out_stall) begin
            if (pending_scores.size() == 0) begin
                report_mismatch($sformatf("result beat for node %0d with none expected",
                                          out_data.node_out));
            end else begin
                want    = pending_scores.pop_front();
                got_sc  = '{out_data.score_0, out_data.score_1, out_data.score_2,
                            out_data.score_3, out_data.score_4, out_data.score_5,
                            out_data.score_6};
                want_sc = '{want.score_0, want.score_1, want.score_2, want.score_3,
                            want.score_4, want.score_5, want.score_6};
                if (out_data.node_out !== want.node_out)
                    report_mismatch($sformatf("node_out got %0d want %0d",
                                              out_data.node_out, want.node_out));
                for (int j = 0; j < NUM_OUT_SCORES; j++) begin
                    if (got_sc[j] !== want_sc[j])
                        report_mismatch($sformatf("node %0d score_%0d got %0d want %0d",
                                                  want.node_out, j, got_sc[j], want_sc[j]));
                end
            end
            recv_hold = no_gaps ? 0 : $urandom_range(0, 3);
        end
        // hold off the receiver after each beat until the drawn hold count runs out
        out_stall <= (recv_hold != 0);
        if (recv_hold != 0)
            recv_hold--;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
